@@ hw/rtl/aes_pkg.sv @@
// AES-128 shared package: S-box, round constants and round helper functions.
// No dependencies; used by round cell, encrypt top, checker and testbench.
`default_nettype none
package aes_pkg;

   localparam int NumRounds = 10;

   typedef logic [127:0] state_type;

   typedef enum logic [0:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] RCON [NumRounds] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   // byte i of a block, byte 0 in the top bits
   function automatic logic [7:0] get_byte(input state_type s, input int i);
      get_byte = s[127-8*i -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // SubBytes followed by ShiftRows
   function automatic state_type sub_shift(input state_type s);
      state_type t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
         end
      end
      sub_shift = t;
   endfunction

   function automatic state_type mix_columns(input state_type s);
      state_type   t;
      logic [7:0]  a0, a1, a2, a3, all;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0  = get_byte(s, 4*c);
         a1  = get_byte(s, 4*c+1);
         a2  = get_byte(s, 4*c+2);
         a3  = get_byte(s, 4*c+3);
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         t[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         t[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      mix_columns = t;
   endfunction

   // one step of the key expansion
   function automatic state_type next_key(input state_type k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, tw;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      tw = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ tw;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      next_key = {w0, w1, w2, w3};
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/aes128_block_encrypt_top.sv @@
// AES-128 encrypt top: key registers, initial key add and a chain of ten round cells.
// Depends on aes_pkg and aes_round_cell.
`default_nettype none
// A block is taken with start whenever busy is low; busy is never raised, so a new
// block may enter every cycle. Each ciphertext appears on rsp_ for one cycle with
// rsp_valid, after one register for the initial key add and one for each of the
// ten round cells. The receiver cannot stall the output.
// Keys may only be changed while no block is in flight.
module aes128_block_encrypt_top
   import aes_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   output logic             rsp_valid,
   output logic [63:0]      rsp_cipher_high,
   output logic [63:0]      rsp_cipher_low,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_data
);

   logic [63:0] key_high_ff, key_low_ff;
   logic        valid0_ff;
   state_type   state0_ff, key0_ff;
   logic        cv   [NumRounds+1];
   state_type   cs   [NumRounds+1];
   state_type   ck   [NumRounds+1];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // initial AddRoundKey stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else begin
         valid0_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      state0_ff <= {req_block_high, req_block_low} ^ {key_high_ff, key_low_ff};
      key0_ff   <= {key_high_ff, key_low_ff};
   end

   assign cv[0] = valid0_ff;
   assign cs[0] = state0_ff;
   assign ck[0] = key0_ff;

   // round chain
   for (genvar r = 0; r < NumRounds; r++) begin : g_round
      aes_round_cell #(
         .RoundConst (RCON[r]),
         .LastRound  (r == NumRounds - 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (cv[r]),
         .state_in  (cs[r]),
         .key_in    (ck[r]),
         .valid_out (cv[r+1]),
         .state_out (cs[r+1]),
         .key_out   (ck[r+1])
      );
   end

   assign rsp_valid       = cv[NumRounds];
   assign rsp_cipher_high = cs[NumRounds][127:64];
   assign rsp_cipher_low  = cs[NumRounds][63:0];

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##11 rsp_valid) else $error("result beat missing");
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##11 !rsp_valid) else $error("unexpected result beat");
   a_key_stable: assert property (@(posedge clock) disable iff (reset)
      valid0_ff |-> key0_ff == $past({key_high_ff, key_low_ff}))
      else $error("round key mismatch");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/aes_round_cell.sv @@
// One AES round cell of the encrypt chain: holds a block and its round key.
// Depends on aes_pkg.
`default_nettype none
module aes_round_cell
   import aes_pkg::*;
#(
   parameter logic [7:0] RoundConst = 8'h01,
   parameter bit         LastRound  = 1'b0
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      valid_in,
   input  wire state_type state_in,
   input  wire state_type key_in,
   output logic           valid_out,
   output state_type      state_out,
   output state_type      key_out
);

   logic      valid_ff, valid_in_d;
   state_type state_ff, state_in_d;
   state_type key_ff, key_in_d;
   state_type sub_d;

   // round datapath
   always_comb begin
      sub_d      = sub_shift(state_in);
      key_in_d   = next_key(key_in, RoundConst);
      state_in_d = (LastRound ? sub_d : mix_columns(sub_d)) ^ key_in_d;
      valid_in_d = valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_d;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in_d;
      key_ff   <= key_in_d;
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign key_out   = key_ff;

`ifndef SYNTHESIS
   a_valid_follows: assert property (@(posedge clock) disable iff (reset)
      valid_in |=> valid_out) else $error("cell lost a beat");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !valid_in |=> !valid_out) else $error("cell invented a beat");
   a_key_step: assert property (@(posedge clock) disable iff (reset)
      valid_in |=> key_out[127:96] != ($past(key_in[127:96]) ^ 32'h0) ||
                   key_out[31:0] == (key_out[63:32] ^ $past(key_in[31:0])))
      else $error("key schedule word mismatch");
`endif

endmodule
`default_nettype wire

@@ test/aes128_block_encrypt_checker.sv @@
// Checker for aes128_block_encrypt_top: tracks key writes and plaintext beats,
// predicts each ciphertext and compares it with the rsp_ beats. Depends on aes_pkg.
`timescale 1ns / 100ps
module aes128_block_encrypt_checker
   import aes_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   input  wire logic        rsp_valid,
   input  wire logic [63:0] rsp_cipher_high,
   input  wire logic [63:0] rsp_cipher_low,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_data,
   output int               fail_count,
   output int               pending_count
);

   // cipher key as the block sees it
   logic [63:0]  key_hi_q, key_lo_q;
   logic [127:0] cipher_q[$];

   localparam logic [7:0] SUB [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // full AES-128 on byte arrays, byte 0 = most significant
   function automatic logic [127:0] encrypt(input logic [127:0] pt, input logic [127:0] key);
      logic [7:0] st[16], rk[16], tmp[16], t0, t1, t2, t3, a0, a1, a2, a3, x;
      logic [7:0] rc;
      logic [127:0] res;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) begin
         st[i] = pt[127-8*i -: 8] ^ key[127-8*i -: 8];
         rk[i] = key[127-8*i -: 8];
      end
      for (int rnd = 0; rnd < 10; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               tmp[4*c+r] = SUB[st[4*((c+r)%4)+r]];
         st = tmp;
         if (rnd < 9) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               x = a0 ^ a1 ^ a2 ^ a3;
               st[4*c]   = a0 ^ x ^ dbl(a0 ^ a1);
               st[4*c+1] = a1 ^ x ^ dbl(a1 ^ a2);
               st[4*c+2] = a2 ^ x ^ dbl(a2 ^ a3);
               st[4*c+3] = a3 ^ x ^ dbl(a3 ^ a0);
            end
         end
         // key schedule step
         t0 = SUB[rk[13]] ^ rc; t1 = SUB[rk[14]]; t2 = SUB[rk[15]]; t3 = SUB[rk[12]];
         rk[0] ^= t0; rk[1] ^= t1; rk[2] ^= t2; rk[3] ^= t3;
         for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
         rc = dbl(rc);
         for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
      return res;
   endfunction

   assign pending_count = cipher_q.size();

   always @(posedge clock) begin
      logic [127:0] want;
      if (reset) begin
         key_hi_q <= '0;
         key_lo_q <= '0;
         cipher_q.delete();
         fail_count <= 0;
      end else begin
         // key writes
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_KEY_HIGH) key_hi_q <= csr_data;
            else key_lo_q <= csr_data;
         end
         // compare response beat against oldest prediction
         if (rsp_valid) begin
            if (cipher_q.size() == 0) begin
               $error("unexpected ciphertext beat %h %h", rsp_cipher_high, rsp_cipher_low);
               fail_count <= fail_count + 1;
            end else begin
               want = cipher_q.pop_front();
               if (rsp_cipher_high !== want[127:64]) begin
                  $error("cipher_high: expected %h, got %h", want[127:64], rsp_cipher_high);
                  fail_count <= fail_count + 1;
               end else if (rsp_cipher_low !== want[63:0]) begin
                  $error("cipher_low: expected %h, got %h", want[63:0], rsp_cipher_low);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // plaintext beat
         if (start && !busy)
            cipher_q.push_back(encrypt({req_block_high, req_block_low},
                                       {key_hi_q, key_lo_q}));
      end
   end

endmodule

@@ test/tb_aes128_block_encrypt_top.sv @@
// Testbench top for aes128_block_encrypt_top: clock, reset, key and plaintext stimulus.
// Depends on aes_pkg, the block and aes128_block_encrypt_checker.
`timescale 1ns / 100ps
module tb_aes128_block_encrypt_top;
   import aes_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low  = '0;
   logic        rsp_valid;
   logic [63:0] rsp_cipher_high, rsp_cipher_low;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_KEY_HIGH;
   logic [63:0] csr_data  = '0;
   int          fail_count, pending_count;
   int          cycle_count = 0;

   localparam int CycleLimit = 200000;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   aes128_block_encrypt_top u_dut (
      .clock, .reset, .start, .busy, .req_block_high, .req_block_low,
      .rsp_valid, .rsp_cipher_high, .rsp_cipher_low,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   aes128_block_encrypt_checker u_checker (
      .clock, .reset, .start, .busy, .req_block_high, .req_block_low,
      .rsp_valid, .rsp_cipher_high, .rsp_cipher_low,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending_count
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("** aes128_block_encrypt_top: FAILED **");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // one key register write beat
   task automatic write_key(input csr_index_type idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one plaintext beat; start stays high across back-to-back beats
   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input bit last);
      start          <= 1'b1;
      req_block_high <= hi;
      req_block_low  <= lo;
      do @(posedge clock); while (busy);
      if (last) start <= 1'b0;
   endtask

   // drain the pipeline before touching the key
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (14) @(posedge clock);
   endtask

   // bursts of random and fixed-pattern plaintexts, usually separated by random gaps
   task automatic random_blocks(input int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         if (burst > count) burst = count;
         for (int i = 0; i < burst; i++) begin
            case ($urandom_range(0, 9))
               0:       send_block('0, '1, i == burst - 1);
               1:       send_block('1, '0, i == burst - 1);
               default: send_block(rand64(), rand64(), i == burst - 1);
            endcase
         end
         count -= burst;
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset key (all zero), directed extremes
      send_block('0, '0, 1'b0);
      send_block('1, '1, 1'b0);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
      send_block(64'h8000000000000000, 64'h0000000000000001, 1'b1);
      drain();

      // standard test vector key, then all-ones
      write_key(CSR_KEY_HIGH, 64'h0001020304050607);
      write_key(CSR_KEY_LOW,  64'h08090a0b0c0d0e0f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
      send_block('0, '0, 1'b0);
      send_block('1, '1, 1'b1);
      drain();
      write_key(CSR_KEY_HIGH, '1);
      write_key(CSR_KEY_LOW,  '1);
      send_block('0, '0, 1'b0);
      send_block('1, '1, 1'b0);
      send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1);
      drain();

      // random phases with random keys, plus zero key once more
      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 4) begin
            write_key(CSR_KEY_HIGH, '0);
            write_key(CSR_KEY_LOW,  '0);
         end else begin
            write_key(CSR_KEY_HIGH, rand64());
            write_key(CSR_KEY_LOW,  rand64());
         end
         random_blocks(150);
         drain();
      end

      if (fail_count == 0)
         $display("** aes128_block_encrypt_top: PASSED **");
      else
         $display("** aes128_block_encrypt_top: FAILED **");
      $finish;
   end

   initial begin
      @(negedge reset);
   end

endmodule
